// ----- design/hkrb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hkrb_pkg
// Shared types and constants of the keyboard report builder.
// ----------------------------------------------------------------------------
package hkrb_pkg;

    localparam int BOOT_SLOTS_DEF  = 6;
    localparam int MEDIA_SLOTS_DEF = 3;

    // Number of slots that the output report fields can carry.
    localparam int BOOT_LIST_SLOTS  = 6;
    localparam int MEDIA_LIST_SLOTS = 3;

    localparam logic [15:0] MOD_FIRST    = 16'h00E0;
    localparam logic [15:0] MOD_LAST     = 16'h00E7;
    localparam logic [15:0] BOOT_MAX     = 16'd231;
    localparam logic [15:0] MEDIA_OFFSET = 16'd255;

    typedef enum logic [1:0] {
        KIND_PRESS   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_REL_ALL = 2'd2,
        KIND_SEND    = 2'd3
    } hkrb_kind_t;

    localparam logic REPORT_BOOT  = 1'b0;
    localparam logic REPORT_MEDIA = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SEND_BOOT,
        ST_SEND_MEDIA
    } hkrb_state_t;

    typedef struct packed {
        logic mod_update;  // apply the incoming modifier press or release
        logic clear_all;   // release every key and modifier
        logic start;       // latch key, bank and direction, rewind the slot index
        logic step;        // advance the slot index
        logic fill;        // write the key into the current slot
        logic remove;      // drop the current slot and close the gap
        logic load_boot;   // put the boot report into the output register
        logic load_media;  // put the media report into the output register
    } hkrb_cmd_t;

    typedef struct packed {
        logic cls_mod;
        logic cls_boot;
        logic cls_media;
        logic press;
        logic slot_empty;
        logic slot_match;
        logic slot_last;
        logic boot_dirty;
        logic media_dirty;
        logic out_free;
    } hkrb_status_t;

endpackage : hkrb_pkg
`default_nettype wire

// ----- design/hkrb_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hkrb_ctrl
// Sequencer: decodes each event and steps the slot scan and the report sends.
// ----------------------------------------------------------------------------
module hkrb_ctrl
    import hkrb_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    input  wire logic [1:0]   in_kind,
    output logic              in_ready,
    input  wire hkrb_status_t status,
    output hkrb_cmd_t         cmd
);

    hkrb_state_t state_reg;
    hkrb_state_t state_next;
    logic        accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (hkrb_kind_t'(in_kind))
                        KIND_PRESS, KIND_RELEASE:
                        begin
                            if (status.cls_mod)
                            begin
                                cmd.mod_update = 1'b1;
                            end
                            else if (status.cls_boot || status.cls_media)
                            begin
                                cmd.start  = 1'b1;
                                state_next = ST_SCAN;
                            end
                        end
                        KIND_REL_ALL:
                        begin
                            cmd.clear_all = 1'b1;
                        end
                        KIND_SEND:
                        begin
                            state_next = ST_SEND_BOOT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (status.press)
                begin
                    priority if (status.slot_empty)
                    begin
                        cmd.fill   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else if (status.slot_match || status.slot_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.step = 1'b1;
                    end
                end
                else
                begin
                    priority if (status.slot_match)
                    begin
                        cmd.remove = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else if (status.slot_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.step = 1'b1;
                    end
                end
            end
            ST_SEND_BOOT:
            begin
                if (!status.boot_dirty)
                begin
                    state_next = ST_SEND_MEDIA;
                end
                else if (status.out_free)
                begin
                    cmd.load_boot = 1'b1;
                    state_next    = ST_SEND_MEDIA;
                end
            end
            ST_SEND_MEDIA:
            begin
                if (!status.media_dirty)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.load_media = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule : hkrb_ctrl
`default_nettype wire

// ----- design/hkrb_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hkrb_datapath
// Key slots, modifier mask, dirty flags, slot scan unit and report register.
// ----------------------------------------------------------------------------
module hkrb_datapath
    import hkrb_pkg::*;
#(
    parameter int BOOT_SLOTS  = BOOT_SLOTS_DEF,
    parameter int MEDIA_SLOTS = MEDIA_SLOTS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [1:0] in_kind,
    input  wire logic [15:0] in_scancode,
    input  wire hkrb_cmd_t  cmd,
    output hkrb_status_t    status,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            out_report_kind,
    output logic [7:0]      out_modifier_bits,
    output logic [47:0]     out_boot_key_list,
    output logic [47:0]     out_media_key_list,
    output logic            out_last_report
);

    localparam int MAX_SLOTS = (BOOT_SLOTS > MEDIA_SLOTS) ? BOOT_SLOTS : MEDIA_SLOTS;
    localparam int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam logic [IDX_W-1:0] BOOT_LAST  = IDX_W'(BOOT_SLOTS - 1);
    localparam logic [IDX_W-1:0] MEDIA_LAST = IDX_W'(MEDIA_SLOTS - 1);

    logic [7:0]       modifier_reg;
    logic [7:0]       boot_reg  [BOOT_SLOTS];
    logic [15:0]      media_reg [MEDIA_SLOTS];
    logic             boot_dirty_reg;
    logic             media_dirty_reg;
    logic [15:0]      key_reg;
    logic             bank_reg;   // 0 boot slots, 1 media slots
    logic             press_reg;
    logic [IDX_W-1:0] idx_reg;

    logic             out_valid_reg;
    logic             out_kind_reg;
    logic [7:0]       out_mod_reg;
    logic [47:0]      out_boot_reg;
    logic [47:0]      out_media_reg;
    logic             out_last_reg;

    logic [7:0]       boot_up  [BOOT_SLOTS];
    logic [15:0]      media_up [MEDIA_SLOTS];
    logic [15:0]      cur_slot;
    logic [7:0]       mod_bit;
    logic [7:0]       mod_new;
    logic             is_press;
    logic [47:0]      boot_list;
    logic [47:0]      media_list;
    logic             boot_nonzero;
    logic             media_nonzero;

    assign is_press = (hkrb_kind_t'(in_kind) == KIND_PRESS);
    assign mod_bit  = 8'(1) << in_scancode[2:0];
    assign mod_new  = is_press ? (modifier_reg | mod_bit) : (modifier_reg & ~mod_bit);

    // Contents of each bank moved down by one slot, used to close a gap.
    always_comb
    begin
        for (int k = 0; k < BOOT_SLOTS - 1; k++)
        begin
            boot_up[k] = boot_reg[k + 1];
        end
        boot_up[BOOT_SLOTS - 1] = 8'd0;
        for (int k = 0; k < MEDIA_SLOTS - 1; k++)
        begin
            media_up[k] = media_reg[k + 1];
        end
        media_up[MEDIA_SLOTS - 1] = 16'd0;
    end

    always_comb
    begin
        cur_slot = 16'd0;
        if (bank_reg)
        begin
            for (int k = 0; k < MEDIA_SLOTS; k++)
            begin
                if (idx_reg == IDX_W'(k))
                begin
                    cur_slot = media_reg[k];
                end
            end
        end
        else
        begin
            for (int k = 0; k < BOOT_SLOTS; k++)
            begin
                if (idx_reg == IDX_W'(k))
                begin
                    cur_slot = {8'd0, boot_reg[k]};
                end
            end
        end
    end

    always_comb
    begin
        boot_list     = '0;
        media_list    = '0;
        boot_nonzero  = 1'b0;
        media_nonzero = 1'b0;
        for (int k = 0; k < BOOT_SLOTS; k++)
        begin
            if (k < BOOT_LIST_SLOTS)
            begin
                boot_list[8*k +: 8] = boot_reg[k];
            end
            boot_nonzero = boot_nonzero | (boot_reg[k] != 8'd0);
        end
        for (int k = 0; k < MEDIA_SLOTS; k++)
        begin
            if (k < MEDIA_LIST_SLOTS)
            begin
                media_list[16*k +: 16] = media_reg[k];
            end
            media_nonzero = media_nonzero | (media_reg[k] != 16'd0);
        end
    end

    always_comb
    begin
        status.cls_mod     = (in_scancode >= MOD_FIRST) && (in_scancode <= MOD_LAST);
        status.cls_boot    = (in_scancode != 16'd0) && (in_scancode <= BOOT_MAX);
        status.cls_media   = (in_scancode > MEDIA_OFFSET);
        status.press       = press_reg;
        status.slot_empty  = (cur_slot == 16'd0);
        status.slot_match  = (cur_slot == key_reg);
        status.slot_last   = bank_reg ? (idx_reg == MEDIA_LAST) : (idx_reg == BOOT_LAST);
        status.boot_dirty  = boot_dirty_reg;
        status.media_dirty = media_dirty_reg;
        status.out_free    = !out_valid_reg || out_ready;
    end

    // Scan registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= '0;
            bank_reg  <= 1'b0;
            press_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (cmd.start)
        begin
            bank_reg  <= status.cls_media;
            press_reg <= is_press;
            idx_reg   <= '0;
            key_reg   <= status.cls_media ? (in_scancode - MEDIA_OFFSET) : in_scancode;
        end
        else if (cmd.step)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    // Key state and dirty flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modifier_reg    <= '0;
            boot_dirty_reg  <= 1'b0;
            media_dirty_reg <= 1'b0;
            for (int k = 0; k < BOOT_SLOTS; k++)
            begin
                boot_reg[k] <= '0;
            end
            for (int k = 0; k < MEDIA_SLOTS; k++)
            begin
                media_reg[k] <= '0;
            end
        end
        else
        begin
            priority if (cmd.clear_all)
            begin
                modifier_reg <= '0;
                for (int k = 0; k < BOOT_SLOTS; k++)
                begin
                    boot_reg[k] <= '0;
                end
                for (int k = 0; k < MEDIA_SLOTS; k++)
                begin
                    media_reg[k] <= '0;
                end
                if ((modifier_reg != 8'd0) || boot_nonzero)
                begin
                    boot_dirty_reg <= 1'b1;
                end
                if (media_nonzero)
                begin
                    media_dirty_reg <= 1'b1;
                end
            end
            else if (cmd.mod_update)
            begin
                if (mod_new != modifier_reg)
                begin
                    modifier_reg   <= mod_new;
                    boot_dirty_reg <= 1'b1;
                end
            end
            else if (cmd.fill)
            begin
                if (bank_reg)
                begin
                    for (int k = 0; k < MEDIA_SLOTS; k++)
                    begin
                        if (idx_reg == IDX_W'(k))
                        begin
                            media_reg[k] <= key_reg;
                        end
                    end
                    media_dirty_reg <= 1'b1;
                end
                else
                begin
                    for (int k = 0; k < BOOT_SLOTS; k++)
                    begin
                        if (idx_reg == IDX_W'(k))
                        begin
                            boot_reg[k] <= key_reg[7:0];
                        end
                    end
                    boot_dirty_reg <= 1'b1;
                end
            end
            else if (cmd.remove)
            begin
                if (bank_reg)
                begin
                    for (int k = 0; k < MEDIA_SLOTS; k++)
                    begin
                        if (IDX_W'(k) >= idx_reg)
                        begin
                            media_reg[k] <= media_up[k];
                        end
                    end
                    media_dirty_reg <= 1'b1;
                end
                else
                begin
                    for (int k = 0; k < BOOT_SLOTS; k++)
                    begin
                        if (IDX_W'(k) >= idx_reg)
                        begin
                            boot_reg[k] <= boot_up[k];
                        end
                    end
                    boot_dirty_reg <= 1'b1;
                end
            end
            else if (cmd.load_boot)
            begin
                boot_dirty_reg <= 1'b0;
            end
            else if (cmd.load_media)
            begin
                media_dirty_reg <= 1'b0;
            end
        end
    end

    // Output register: holds a report until the downstream side takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_boot || cmd.load_media)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_kind_reg  <= REPORT_BOOT;
            out_mod_reg   <= '0;
            out_boot_reg  <= '0;
            out_media_reg <= '0;
            out_last_reg  <= 1'b0;
        end
        else if (cmd.load_boot)
        begin
            out_kind_reg  <= REPORT_BOOT;
            out_mod_reg   <= modifier_reg;
            out_boot_reg  <= boot_list;
            out_media_reg <= '0;
            out_last_reg  <= !media_dirty_reg;
        end
        else if (cmd.load_media)
        begin
            out_kind_reg  <= REPORT_MEDIA;
            out_mod_reg   <= '0;
            out_boot_reg  <= '0;
            out_media_reg <= media_list;
            out_last_reg  <= 1'b1;
        end
    end

    assign out_valid          = out_valid_reg;
    assign out_report_kind    = out_kind_reg;
    assign out_modifier_bits  = out_mod_reg;
    assign out_boot_key_list  = out_boot_reg;
    assign out_media_key_list = out_media_reg;
    assign out_last_report    = out_last_reg;

endmodule : hkrb_datapath
`default_nettype wire

// ----- design/hid_key_report_builder_unit.sv -----
// Modifier, release-all and ignored events finish when accepted; a slot key
// event then scans its bank, one slot compared per cycle. A send visits the
// boot and then the media send state, each waiting out any output stall;
// each report sits in the output register until taken. Throughput: one
// event at a time. Asynchronous active-low reset clears all keys,
// modifiers, dirty flags and the output register at once.
`default_nettype none
// ----------------------------------------------------------------------------
// hid_key_report_builder_unit
// Boot keyboard and media key report builder with change tracking.
// ----------------------------------------------------------------------------
module hid_key_report_builder_unit
    import hkrb_pkg::*;
#(
    parameter int BOOT_SLOTS  = BOOT_SLOTS_DEF,
    parameter int MEDIA_SLOTS = MEDIA_SLOTS_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [15:0]  s_axis_tdata,   // [15:0] scancode
    input  wire logic [1:0]   s_axis_tuser,   // [1:0] kind
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [103:0]      m_axis_tdata,   // [7:0] modifier_bits,
                                              // [55:8] boot_key_list,
                                              // [103:56] media_key_list
    output logic [0:0]        m_axis_tuser,   // [0] report_kind
    output logic              m_axis_tlast    // last_report
);

    hkrb_cmd_t    cmd;
    hkrb_status_t status;
    logic [7:0]   modifier_bits;
    logic [47:0]  boot_key_list;
    logic [47:0]  media_key_list;

    hkrb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_kind  (s_axis_tuser),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    hkrb_datapath #(
        .BOOT_SLOTS  (BOOT_SLOTS),
        .MEDIA_SLOTS (MEDIA_SLOTS)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_kind            (s_axis_tuser),
        .in_scancode        (s_axis_tdata),
        .cmd                (cmd),
        .status             (status),
        .out_valid          (m_axis_tvalid),
        .out_ready          (m_axis_tready),
        .out_report_kind    (m_axis_tuser[0]),
        .out_modifier_bits  (modifier_bits),
        .out_boot_key_list  (boot_key_list),
        .out_media_key_list (media_key_list),
        .out_last_report    (m_axis_tlast)
    );

    assign m_axis_tdata = {media_key_list, boot_key_list, modifier_bits};

endmodule : hid_key_report_builder_unit
`default_nettype wire

// ----- design/hkrb_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hkrb_checker
// Port-level checks of the report builder, bound to the top level.
// ----------------------------------------------------------------------------
module hkrb_checker
    import hkrb_pkg::*;
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [103:0] m_axis_tdata,
    input wire logic [0:0]   m_axis_tuser,
    input wire logic         m_axis_tlast
);

    // A pending transaction stays offered until taken.
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result transaction dropped before it was taken");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // The media report is always the final report of a send.
    a_media_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[0] == REPORT_MEDIA) |-> m_axis_tlast)
        else $error("media report not marked last");

    a_boot_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[0] == REPORT_BOOT) |-> (m_axis_tdata[103:56] == '0))
        else $error("boot report carries media keys");

    a_media_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[0] == REPORT_MEDIA) |-> (m_axis_tdata[55:0] == '0))
        else $error("media report carries boot keys or modifiers");

endmodule : hkrb_checker

bind hid_key_report_builder_unit hkrb_checker u_hkrb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

// ----- sim/hid_key_report_builder_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hid_key_report_builder_unit_test
// Drives key events into the report builder and checks every emitted report
// against a behavioral predictor of the modifier mask, the boot and media key
// slots and the per-report change flags, under random stalls on both streams.
// ----------------------------------------------------------------------------
module hid_key_report_builder_unit_test;
    import hkrb_pkg::*;

    typedef struct {
        logic        report_kind;
        logic [7:0]  modifier_bits;
        logic [47:0] boot_key_list;
        logic [47:0] media_key_list;
        logic        last_report;
    } key_report_t;

    class key_report_scoreboard;
        logic [7:0]  mod_mask;
        logic [15:0] boot_held[$];
        logic [15:0] media_held[$];
        bit          boot_stale;
        bit          media_stale;
        key_report_t pending[$];
        int          errors;

        function new();
            mod_mask    = 8'h00;
            boot_stale  = 1'b0;
            media_stale = 1'b0;
            errors      = 0;
        endfunction

        // Keys always sit packed at the front of a bank, so a queue of the held
        // keys stands for the slots with the zeros trailing.
        function bit bank_event(bit media_bank, bit press, logic [15:0] key);
            logic [15:0] held[$];
            int          cap;
            int          found;
            bit          changed;
            if (media_bank)
            begin
                held = media_held;
                cap  = MEDIA_SLOTS_DEF;
            end
            else
            begin
                held = boot_held;
                cap  = BOOT_SLOTS_DEF;
            end
            found   = -1;
            changed = 1'b0;
            foreach (held[i])
            begin
                if (held[i] == key)
                    found = i;
            end
            if (press && found < 0 && held.size() < cap)
            begin
                held.push_back(key);
                changed = 1'b1;
            end
            else if (!press && found >= 0)
            begin
                held.delete(found);
                changed = 1'b1;
            end
            if (media_bank)
                media_held = held;
            else
                boot_held = held;
            return changed;
        endfunction

        function void note_event(hkrb_kind_t kind, logic [15:0] code);
            logic [7:0]  next_mask;
            key_report_t rpt;
            case (kind)
                KIND_PRESS, KIND_RELEASE:
                begin
                    if (code >= MOD_FIRST && code <= MOD_LAST)
                    begin
                        next_mask = (kind == KIND_PRESS) ? (mod_mask | (8'd1 << code[2:0]))
                                                         : (mod_mask & ~(8'd1 << code[2:0]));
                        if (next_mask != mod_mask)
                        begin
                            mod_mask   = next_mask;
                            boot_stale = 1'b1;
                        end
                    end
                    else if (code >= 16'd1 && code <= BOOT_MAX)
                    begin
                        if (bank_event(1'b0, kind == KIND_PRESS, code))
                            boot_stale = 1'b1;
                    end
                    else if (code > MEDIA_OFFSET)
                    begin
                        if (bank_event(1'b1, kind == KIND_PRESS, code - MEDIA_OFFSET))
                            media_stale = 1'b1;
                    end
                end
                KIND_REL_ALL:
                begin
                    if (mod_mask != 8'h00 || boot_held.size() != 0)
                        boot_stale = 1'b1;
                    if (media_held.size() != 0)
                        media_stale = 1'b1;
                    mod_mask = 8'h00;
                    boot_held.delete();
                    media_held.delete();
                end
                KIND_SEND:
                begin
                    if (boot_stale)
                    begin
                        rpt.report_kind    = REPORT_BOOT;
                        rpt.modifier_bits  = mod_mask;
                        rpt.boot_key_list  = '0;
                        rpt.media_key_list = '0;
                        rpt.last_report    = !media_stale;
                        foreach (boot_held[i])
                            rpt.boot_key_list[8*i +: 8] = boot_held[i][7:0];
                        pending.push_back(rpt);
                        boot_stale = 1'b0;
                    end
                    if (media_stale)
                    begin
                        rpt.report_kind    = REPORT_MEDIA;
                        rpt.modifier_bits  = 8'h00;
                        rpt.boot_key_list  = '0;
                        rpt.media_key_list = '0;
                        rpt.last_report    = 1'b1;
                        foreach (media_held[i])
                            rpt.media_key_list[16*i +: 16] = media_held[i];
                        pending.push_back(rpt);
                        media_stale = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        function void compare_field(string name, logic [47:0] want, logic [47:0] got);
            if (got !== want)
            begin
                $error("%s: expected %h, actual %h", name, want, got);
                errors++;
            end
        endfunction

        function void check_report(logic [103:0] data, logic kind_bit, logic last);
            key_report_t want;
            if (pending.size() == 0)
            begin
                $error("report with nothing expected: tdata=%h tuser=%b tlast=%b",
                       data, kind_bit, last);
                errors++;
                return;
            end
            want = pending.pop_front();
            compare_field("report_kind", 48'(want.report_kind), 48'(kind_bit));
            compare_field("modifier_bits", 48'(want.modifier_bits), 48'(data[7:0]));
            compare_field("boot_key_list", want.boot_key_list, data[55:8]);
            compare_field("media_key_list", want.media_key_list, data[103:56]);
            compare_field("last_report", 48'(want.last_report), 48'(last));
        endfunction
    endclass

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [15:0]  s_axis_tdata = 16'h0000;
    logic [1:0]   s_axis_tuser = KIND_PRESS;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;
    logic [0:0]   m_axis_tuser;
    logic         m_axis_tlast;

    int gap_odds = 0;
    int stall_odds = 0;
    int stall_left = 0;

    key_report_scoreboard sb = new();

    hid_key_report_builder_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver back-pressure: random stall bursts on tready.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(0, 9);
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_report(m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
    end

    // The valid line is only lowered before a gap, so it never drops and rises
    // again within one time step.
    task automatic drive_event(hkrb_kind_t kind, logic [15:0] code);
        int gap;
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            gap = $urandom_range(1, 10);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= code;
        s_axis_tuser  <= kind;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_event(kind, code);
    endtask

    // Small key pools make duplicates, full banks and releases of held keys common.
    function automatic logic [15:0] pick_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 16'($urandom_range(1, 10));
        else if (r < 48)
            return 16'($urandom_range(1, 231));
        else if (r < 63)
            return MOD_FIRST + 16'($urandom_range(0, 7));
        else if (r < 80)
            return 16'($urandom_range(256, 261));
        else if (r < 88)
            return 16'($urandom_range(256, 65535));
        else if (r < 91)
            return 16'h0000;
        else if (r < 94)
            return 16'($urandom_range(232, 255));
        else
            return 16'($urandom_range(0, 65535));
    endfunction

    function automatic hkrb_kind_t pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 42)
            return KIND_PRESS;
        else if (r < 72)
            return KIND_RELEASE;
        else if (r < 76)
            return KIND_REL_ALL;
        else
            return KIND_SEND;
    endfunction

    initial
    begin
        int sel;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        gap_odds   = 3;
        stall_odds = 3;

        drive_event(KIND_SEND, 16'h0000);
        drive_event(KIND_PRESS, 16'h0000);
        drive_event(KIND_RELEASE, 16'h0000);
        drive_event(KIND_PRESS, MOD_FIRST);
        drive_event(KIND_PRESS, MOD_LAST);
        drive_event(KIND_PRESS, 16'd231);
        drive_event(KIND_PRESS, 16'd1);
        drive_event(KIND_PRESS, 16'd232);
        drive_event(KIND_PRESS, 16'd255);
        drive_event(KIND_PRESS, 16'd256);
        drive_event(KIND_PRESS, 16'hFFFF);
        drive_event(KIND_SEND, 16'h0000);
        drive_event(KIND_PRESS, 16'd231);
        drive_event(KIND_RELEASE, 16'd231);
        drive_event(KIND_RELEASE, 16'd100);
        for (int k = 2; k <= 7; k++)
            drive_event(KIND_PRESS, 16'(k));
        drive_event(KIND_RELEASE, 16'd3);
        drive_event(KIND_PRESS, 16'd257);
        drive_event(KIND_PRESS, 16'd258);
        drive_event(KIND_RELEASE, MOD_LAST);
        drive_event(KIND_SEND, 16'hFFFF);
        drive_event(KIND_REL_ALL, 16'hFFFF);
        drive_event(KIND_SEND, 16'hFFFF);
        drive_event(KIND_REL_ALL, 16'h0000);
        drive_event(KIND_SEND, 16'h0000);

        for (int n = 0; n < 1850; n++)
        begin
            if (n >= 1600)
            begin
                gap_odds   = 0;
                stall_odds = 0;
            end
            else if (n % 150 == 0)
            begin
                sel = $urandom_range(0, 3);
                case (sel)
                    0: gap_odds = 0;
                    1: gap_odds = 2;
                    2: gap_odds = 4;
                    default: gap_odds = 8;
                endcase
                sel = $urandom_range(0, 3);
                case (sel)
                    0: stall_odds = 0;
                    1: stall_odds = 2;
                    2: stall_odds = 4;
                    default: stall_odds = 8;
                endcase
            end
            drive_event(pick_kind(), pick_code());
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- hid_key_report_builder_unit.f -----
design/hkrb_pkg.sv
design/hkrb_ctrl.sv
design/hkrb_datapath.sv
design/hid_key_report_builder_unit.sv
design/hkrb_checker.sv
sim/hid_key_report_builder_unit_test.sv
